/* rtl/mks_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keying sequencer package
// Shared types, constants and the character to pattern table.
// ----------------------------------------------------------------------------
package mks_pkg;

	localparam int unsigned MKS_QUEUE_DEPTH = 2;
	localparam int unsigned MKS_DOT_W       = 16;
	localparam int unsigned MKS_DUR_W       = 20;
	localparam int unsigned MKS_MAX_ELEM    = 5;
	localparam logic [MKS_DOT_W-1:0] MKS_DOT_RESET = 16'd60;

	typedef logic [MKS_DUR_W-1:0] dur_word_t;

	// Element bits, first element in bit 0; a set bit is a dash.
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] bits;
	} pat_t;

	typedef struct packed {
		pat_t pat;
		logic eot;
	} cmd_t;

	typedef struct packed {
		dur_word_t unit1;
		dur_word_t unit3;
		dur_word_t unit12;
	} dur_set_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ELEM,
		ST_GAP,
		ST_CLOSE
	} seq_state_t;

	function automatic pat_t pattern_lookup(input logic [7:0] ch);
		pat_t r;
		unique case (ch)
			8'h41: r = {3'd2, 5'b00010};
			8'h42: r = {3'd4, 5'b00001};
			8'h43: r = {3'd4, 5'b00101};
			8'h44: r = {3'd3, 5'b00001};
			8'h45: r = {3'd1, 5'b00000};
			8'h46: r = {3'd4, 5'b00100};
			8'h47: r = {3'd3, 5'b00011};
			8'h48: r = {3'd4, 5'b00000};
			8'h49: r = {3'd2, 5'b00000};
			8'h4A: r = {3'd4, 5'b01110};
			8'h4B: r = {3'd3, 5'b00101};
			8'h4C: r = {3'd4, 5'b00010};
			8'h4D: r = {3'd2, 5'b00011};
			8'h4E: r = {3'd2, 5'b00001};
			8'h4F: r = {3'd3, 5'b00111};
			8'h50: r = {3'd4, 5'b00110};
			8'h51: r = {3'd4, 5'b01011};
			8'h52: r = {3'd3, 5'b00010};
			8'h53: r = {3'd3, 5'b00000};
			8'h54: r = {3'd1, 5'b00001};
			8'h55: r = {3'd3, 5'b00100};
			8'h56: r = {3'd4, 5'b01000};
			8'h57: r = {3'd3, 5'b00110};
			8'h58: r = {3'd4, 5'b01001};
			8'h59: r = {3'd4, 5'b01101};
			8'h5A: r = {3'd4, 5'b00011};
			8'h30: r = {3'd5, 5'b11111};
			8'h31: r = {3'd5, 5'b11110};
			8'h32: r = {3'd5, 5'b11100};
			8'h33: r = {3'd5, 5'b11000};
			8'h34: r = {3'd5, 5'b10000};
			8'h35: r = {3'd5, 5'b00000};
			8'h36: r = {3'd5, 5'b00001};
			8'h37: r = {3'd5, 5'b00011};
			8'h38: r = {3'd5, 5'b00111};
			8'h39: r = {3'd5, 5'b01111};
			default: r = {3'd0, 5'b00000};
		endcase
		return r;
	endfunction

endpackage

/* rtl/morse_keying_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keying sequencer core
// Turns characters into timed dot, dash and gap key segments.
// An accepted character passes the front-end register, the command queue and the
// sequencer state before its first segment is registered. A character of E elements
// yields 2E+1 segments (1 to 11), one per cycle unless out_ready stalls the output.
// Reset: arst_n clears all control state and sets the dot unit to 60 ticks.
// ----------------------------------------------------------------------------
module morse_keying_sequencer_core
	import mks_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = MKS_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MKS_DOT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           character,
	input  logic                 end_of_text,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 dot_key,
	output logic                 dash_key,
	output logic [MKS_DUR_W-1:0] duration,
	output logic                 last_segment
);

	dur_set_t  durs_q;
	dur_word_t wr_unit1;
	dur_word_t wr_unit3;
	logic      f_valid;
	logic      f_ready;
	cmd_t      f_cmd;
	logic      q_valid;
	logic      q_ready;
	cmd_t      q_cmd;

	assign cfg_ready = 1'b1;
	assign wr_unit1  = MKS_DUR_W'(cfg_data);
	assign wr_unit3  = wr_unit1 + {wr_unit1[MKS_DUR_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			durs_q.unit1  <= MKS_DUR_W'(MKS_DOT_RESET);
			durs_q.unit3  <= MKS_DUR_W'(MKS_DOT_RESET * 3);
			durs_q.unit12 <= MKS_DUR_W'(MKS_DOT_RESET * 12);
		end else if (cfg_valid && cfg_ready) begin
			durs_q.unit1  <= wr_unit1;
			durs_q.unit3  <= wr_unit3;
			durs_q.unit12 <= {wr_unit3[MKS_DUR_W-3:0], 2'b00};
		end
	end

	mks_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.character   (character),
		.end_of_text (end_of_text),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd         (f_cmd)
	);

	mks_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	mks_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_ready    (q_ready),
		.cmd          (q_cmd),
		.durs         (durs_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dot_key      (dot_key),
		.dash_key     (dash_key),
		.duration     (duration),
		.last_segment (last_segment)
	);

endmodule

/* rtl/mks_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keying front end
// Accepts characters, looks up their element patterns and hands commands on.
// ----------------------------------------------------------------------------
module mks_front
	import mks_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       end_of_text,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	logic valid_s1;
	cmd_t cmd_s1;

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.pat <= pattern_lookup(character);
			cmd_s1.eot <= end_of_text;
		end
	end

endmodule

/* rtl/mks_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keying command queue
// Small first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module mks_queue
	import mks_pkg::*;
#(
	parameter int unsigned DEPTH = MKS_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/mks_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keying segment sequencer
// Walks the element pattern of each command and emits one segment a cycle while out_ready does not stall it.
// ----------------------------------------------------------------------------
module mks_back
	import mks_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	input  dur_set_t             durs,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 dot_key,
	output logic                 dash_key,
	output logic [MKS_DUR_W-1:0] duration,
	output logic                 last_segment
);

	seq_state_t           state_q;
	seq_state_t           state_nx;
	logic [4:0]           bits_q;
	logic [2:0]           len_q;
	logic                 eot_q;
	logic [2:0]           idx_q;
	logic                 out_valid_q;
	logic                 dot_q;
	logic                 dash_q;
	dur_word_t            dur_q;
	logic                 last_q;
	logic                 out_free;
	logic                 emit;
	logic                 pop;
	logic                 more_elem;
	logic                 seg_dot;
	logic                 seg_dash;
	dur_word_t            seg_dur;
	logic                 seg_last;
	seq_state_t           load_state;

	assign out_free   = !out_valid_q || out_ready;
	assign emit       = (state_q != ST_IDLE) && out_free;
	assign pop        = cmd_valid && ((state_q == ST_IDLE) || ((state_q == ST_CLOSE) && emit));
	assign cmd_ready  = pop;
	assign more_elem  = (idx_q + 3'd1) < len_q;
	assign load_state = (cmd.pat.len != 3'd0) ? ST_ELEM : ST_CLOSE;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop) state_nx = load_state;
			end
			ST_ELEM: begin
				if (out_free) state_nx = ST_GAP;
			end
			ST_GAP: begin
				if (out_free) state_nx = more_elem ? ST_ELEM : ST_CLOSE;
			end
			ST_CLOSE: begin
				if (out_free) state_nx = pop ? load_state : ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		seg_dot  = 1'b0;
		seg_dash = 1'b0;
		seg_dur  = durs.unit1;
		seg_last = 1'b0;
		unique case (state_q)
			ST_ELEM: begin
				seg_dash = bits_q[idx_q];
				seg_dot  = !bits_q[idx_q];
				seg_dur  = bits_q[idx_q] ? durs.unit3 : durs.unit1;
			end
			ST_CLOSE: begin
				seg_dur  = eot_q ? durs.unit12 : durs.unit3;
				seg_last = 1'b1;
			end
			default: begin
				seg_dur = durs.unit1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (pop) begin
				idx_q <= '0;
			end else if ((state_q == ST_GAP) && emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bits_q <= cmd.pat.bits;
			len_q  <= cmd.pat.len;
			eot_q  <= cmd.eot;
		end
		if (emit) begin
			dot_q  <= seg_dot;
			dash_q <= seg_dash;
			dur_q  <= seg_dur;
			last_q <= seg_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign dot_key      = dot_q;
	assign dash_key     = dash_q;
	assign duration     = dur_q;
	assign last_segment = last_q;

endmodule
